>>> hdl/hpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared constants and types of the hashed-path perceptron predictor.
// ----------------------------------------------------------------------------
package hpp_pkg;
    localparam int WIDX_BITS   = 14;
    localparam int BIDX_BITS   = 10;
    localparam int PATH_BITS   = 5;
    localparam int HIST_LEN    = 32;
    localparam int POS_BITS    = $clog2(HIST_LEN);
    localparam int SUM_BITS    = 14;
    localparam int ACC_BITS    = 16;
    localparam int THR_BITS    = 13;
    localparam logic [31:0] MUL_ADDR = 32'd511387;
    localparam logic [31:0] MUL_PATH = 32'd660509;
    localparam logic [31:0] MUL_POS  = 32'd1289381;
    localparam logic [THR_BITS-1:0] THR_RESET = 13'd70;
    localparam int WCOUNT = 1 << WIDX_BITS;
    localparam int BCOUNT = 1 << BIDX_BITS;

    typedef struct packed {
        logic load;      // capture item, start clear of accumulator
        logic bias_rd;   // issue bias read
        logic bias_acc;  // add bias read data
        logic hash;      // compute hash for position
        logic w_rd;      // issue weight read at hashed slot
        logic w_acc;     // accumulate weight read data
        logic w_wr;      // write stepped weight back
        logic bias_wr;   // write stepped bias back
        logic decide;    // evaluate train decision
        logic commit;    // update history and path, present result
        logic clr;       // clearing pass write
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic cond;
        logic do_train;
    } sts_t;
endpackage
`default_nettype wire

>>> hdl/hpp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_datapath
// Tables, histories, paths, hash and sum arithmetic of the predictor.
// ----------------------------------------------------------------------------
module hpp_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire hpp_pkg::cmd_t cmd,
    input  wire logic [hpp_pkg::POS_BITS-1:0] pos,
    output hpp_pkg::sts_t sts,
    input  wire logic [hpp_pkg::THR_BITS-1:0] thr,
    input  wire logic [35:0] in_data,
    output logic [15:0] out_data
);
    logic [7:0] wmem [hpp_pkg::WCOUNT];
    logic [7:0] bmem [hpp_pkg::BCOUNT];
    logic [7:0] wrd_reg, brd_reg;
    logic [hpp_pkg::HIST_LEN-1:0] fh_reg, rh_reg, hist_reg;
    logic [31:0] fp_reg [1 << hpp_pkg::PATH_BITS];
    logic [31:0] rp_reg [1 << hpp_pkg::PATH_BITS];
    logic retire_reg, cond_reg, br_reg, tk_reg, train_reg, pred_reg;
    logic [31:0] addr_reg, ah_reg, ph_reg, qh_reg;
    logic [hpp_pkg::WIDX_BITS-1:0] slot_reg;
    logic [hpp_pkg::ACC_BITS-1:0] acc_reg;
    logic [hpp_pkg::WIDX_BITS-1:0] clr_reg;
    logic [31:0] pent;
    logic hbit;
    logic [7:0] wstep, bstep;
    logic [hpp_pkg::ACC_BITS-1:0] wext, mag;
    logic [hpp_pkg::BIDX_BITS-1:0] bidx;

    assign bidx = addr_reg[hpp_pkg::BIDX_BITS-1:0];
    assign pent = retire_reg ? rp_reg[pos[hpp_pkg::PATH_BITS-1:0]]
                             : fp_reg[pos[hpp_pkg::PATH_BITS-1:0]];
    assign hbit = hist_reg[pos];
    assign wext = {{(hpp_pkg::ACC_BITS-8){wrd_reg[7]}}, wrd_reg};
    assign mag = acc_reg[hpp_pkg::ACC_BITS-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign sts.cond = cond_reg;
    assign sts.do_train = train_reg;
    assign sts.clr_done = &clr_reg;

    always_comb
    begin
        if (hbit == tk_reg)
            wstep = (wrd_reg == 8'sd127) ? wrd_reg : wrd_reg + 8'd1;
        else
            wstep = (wrd_reg == 8'h80) ? wrd_reg : wrd_reg - 8'd1;
        if (tk_reg)
            bstep = (brd_reg == 8'sd127) ? brd_reg : brd_reg + 8'd1;
        else
            bstep = (brd_reg == 8'h80) ? brd_reg : brd_reg - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
            wmem[clr_reg] <= 8'd0;
        else if (cmd.w_wr)
            wmem[slot_reg] <= wstep;
        if (cmd.clr)
            bmem[clr_reg[hpp_pkg::BIDX_BITS-1:0]] <= 8'd0;
        else if (cmd.bias_wr)
            bmem[bidx] <= bstep;
        if (cmd.w_rd)
            wrd_reg <= wmem[slot_reg];
        if (cmd.bias_rd)
            brd_reg <= bmem[bidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            fh_reg <= '0;
            rh_reg <= '0;
            for (int k = 0; k < (1 << hpp_pkg::PATH_BITS); k++)
            begin
                fp_reg[k] <= '0;
                rp_reg[k] <= '0;
            end
            train_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.decide)
                train_reg <= retire_reg && ((mag < {3'b0, thr}) ||
                             (!acc_reg[hpp_pkg::ACC_BITS-1] != tk_reg));
            if (cmd.commit && br_reg)
            begin
                if (retire_reg)
                begin
                    rh_reg <= {rh_reg[hpp_pkg::HIST_LEN-2:0], cond_reg ? tk_reg : 1'b1};
                    rp_reg[0] <= addr_reg;
                    for (int k = 1; k < (1 << hpp_pkg::PATH_BITS); k++)
                        rp_reg[k] <= rp_reg[k-1];
                end
                else
                begin
                    fh_reg <= {fh_reg[hpp_pkg::HIST_LEN-2:0], cond_reg ? tk_reg : 1'b1};
                    fp_reg[0] <= addr_reg;
                    for (int k = 1; k < (1 << hpp_pkg::PATH_BITS); k++)
                        fp_reg[k] <= fp_reg[k-1];
                end
            end
        end
    end

    // Hash is split: products are registered, then XOR and mask into the slot register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            retire_reg <= in_data[0];
            addr_reg <= in_data[32:1];
            cond_reg <= in_data[33];
            br_reg <= in_data[34] | in_data[33];
            tk_reg <= in_data[35];
            hist_reg <= in_data[0] ? rh_reg : fh_reg;
            ah_reg <= in_data[32:1] * hpp_pkg::MUL_ADDR;
            acc_reg <= '0;
        end
        if (cmd.hash)
        begin
            ph_reg <= pent * hpp_pkg::MUL_PATH;
            qh_reg <= 32'(pos) * hpp_pkg::MUL_POS;
        end
        if (cmd.bias_acc)
            acc_reg <= acc_reg + {{(hpp_pkg::ACC_BITS-8){brd_reg[7]}}, brd_reg};
        if (cmd.w_acc)
            acc_reg <= hbit ? acc_reg + wext : acc_reg - wext;
        if (cmd.decide)
            pred_reg <= !acc_reg[hpp_pkg::ACC_BITS-1];
    end

    logic [31:0] hx;
    assign hx = ah_reg ^ ph_reg ^ qh_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.w_rd == 1'b0 && cmd.hash == 1'b0 && !cmd.w_wr)
            slot_reg <= hx[hpp_pkg::WIDX_BITS-1:0];
    end

    always_comb
    begin
        out_data = '0;
        if (cond_reg)
        begin
            out_data[0] = 1'b1;
            out_data[1] = pred_reg;
            out_data[hpp_pkg::SUM_BITS+1:2] = acc_reg[hpp_pkg::SUM_BITS-1:0];
        end
    end
endmodule
`default_nettype wire

>>> hdl/hpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_ctrl
// Sequencer for the clearing pass, the sum loop and the training loop.
// ----------------------------------------------------------------------------
module hpp_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_free,
    output logic in_rdy,
    output logic out_load,
    output hpp_pkg::cmd_t cmd,
    output logic [hpp_pkg::POS_BITS-1:0] pos,
    input  wire hpp_pkg::sts_t sts
);
    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_BRD   = 11'b00000000100,
        S_BACC  = 11'b00000001000,
        S_HASH  = 11'b00000010000,
        S_SLOT  = 11'b00000100000,
        S_WRD   = 11'b00001000000,
        S_WACC  = 11'b00010000000,
        S_DEC   = 11'b00100000000,
        S_TRN   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [hpp_pkg::POS_BITS-1:0] pos_reg, pos_next;
    logic trn_reg, trn_next;

    assign pos = pos_reg;
    assign in_rdy = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        trn_next = trn_reg;
        cmd = '0;
        out_load = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    pos_next = '0;
                    trn_next = 1'b0;
                    state_next = S_BRD;
                end
            S_BRD:
            begin
                cmd.bias_rd = 1'b1;
                state_next = sts.cond ? S_BACC : S_DONE;
            end
            S_BACC:
            begin
                if (!trn_reg)
                    cmd.bias_acc = 1'b1;
                else
                    cmd.bias_wr = 1'b1;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                cmd.hash = 1'b1;
                state_next = S_SLOT;
            end
            S_SLOT:
                state_next = S_WRD;
            S_WRD:
            begin
                cmd.w_rd = 1'b1;
                state_next = trn_reg ? S_TRN : S_WACC;
            end
            S_WACC:
            begin
                cmd.w_acc = 1'b1;
                pos_next = pos_reg + 1'b1;
                state_next = (&pos_reg) ? S_DEC : S_HASH;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_DONE;
            end
            S_TRN:
            begin
                cmd.w_wr = 1'b1;
                pos_next = pos_reg + 1'b1;
                state_next = (&pos_reg) ? S_DONE : S_HASH;
            end
            S_DONE:
                if (sts.do_train && !trn_reg && sts.cond)
                begin
                    trn_next = 1'b1;
                    pos_next = '0;
                    state_next = S_BRD;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            pos_reg <= '0;
            trn_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            trn_reg <= trn_next;
        end
    end
endmodule
`default_nettype wire

>>> hdl/hashed_path_perceptron_predictor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_path_perceptron_predictor
// Perceptron branch predictor with hashed path weights, one uop per beat.
// One uop is in flight at a time; the history positions are walked one at a
// time through the single-port weight table, and a conditional uop that
// trains makes a second pass. After reset a clearing pass zeroes the tables
// before the first beat is accepted.
// ----------------------------------------------------------------------------
module hashed_path_perceptron_predictor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // branch_address, is_conditional,
                                        // is_branch, outcome_taken, zero pad
    input  wire logic        s_tuser,  // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // prediction_valid, predicted_taken,
                                        // perceptron_sum[13:0], trained, pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);
    hpp_pkg::cmd_t cmd;
    hpp_pkg::sts_t sts;
    logic [hpp_pkg::POS_BITS-1:0] pos;
    logic [hpp_pkg::THR_BITS-1:0] thr_reg;
    logic [15:0] res;
    logic out_load, in_rdy;
    logic [23:0] tdata_reg;
    logic tvalid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready = in_rdy;
    assign m_tvalid = tvalid_reg;
    assign m_tdata = tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= hpp_pkg::THR_RESET;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (out_load)
                tvalid_reg <= 1'b1;
            else if (m_tready)
                tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            tdata_reg <= {7'd0, sts.do_train & sts.cond, res[15:0]};
    end

    hpp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid & in_rdy),
        .out_free(!tvalid_reg || m_tready), .in_rdy(in_rdy),
        .out_load(out_load), .cmd(cmd), .pos(pos), .sts(sts)
    );

    hpp_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .pos(pos), .sts(sts),
        .thr(thr_reg), .in_data({s_tdata[34:0], s_tuser}), .out_data(res)
    );
endmodule
`default_nettype wire

>>> sim/hashed_path_perceptron_predictor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_path_perceptron_predictor_tb
// Drives fetch and retire uops into the predictor and checks every result
// beat against a behavioral perceptron kept in the bench, across several
// training thresholds and with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module hashed_path_perceptron_predictor_tb;

    typedef enum logic {OP_FETCH = 1'b0, OP_RETIRE = 1'b1} uop_kind_t;

    // Same bit order as m_tdata[16:0]: last field in the lowest bit.
    typedef struct packed {
        logic                         trained;
        logic [hpp_pkg::SUM_BITS-1:0] sum;
        logic                         taken;
        logic                         valid;
    } verdict_t;

    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    hashed_path_perceptron_predictor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Mirror of the predictor state.
    byte               weight_tbl [hpp_pkg::WCOUNT];
    byte               bias_tbl   [hpp_pkg::BCOUNT];
    logic [31:0]       side_hist  [2];
    logic [31:0]       side_path  [2][32];
    logic [hpp_pkg::THR_BITS-1:0] threshold;

    verdict_t    pending_verdicts [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] addr_pool [16];

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic byte step_weight(byte w, bit up);
        if (up)
            return (w == 127) ? w : byte'(w + 1);
        return (w == -128) ? w : byte'(w - 1);
    endfunction

    function automatic logic [hpp_pkg::WIDX_BITS-1:0] slot_of(logic [31:0] a, logic [31:0] p,
                                                             int pos);
        logic [31:0] pos_w;
        logic [31:0] h;
        pos_w = pos;
        h = (a * hpp_pkg::MUL_ADDR) ^ (p * hpp_pkg::MUL_PATH) ^ (pos_w * hpp_pkg::MUL_POS);
        return h[hpp_pkg::WIDX_BITS-1:0];
    endfunction

    function automatic verdict_t predict_uop(uop_kind_t kind, logic [31:0] a, bit c, bit b,
                                             bit t);
        verdict_t v;
        int sum;
        int mag;
        int side;
        bit pred;
        bit train_now;
        logic [hpp_pkg::WIDX_BITS-1:0] s;
        side = (kind == OP_RETIRE) ? 1 : 0;
        sum = 0;
        pred = 1'b0;
        train_now = 1'b0;
        if (c)
        begin
            sum = bias_tbl[a[hpp_pkg::BIDX_BITS-1:0]];
            for (int i = 0; i < hpp_pkg::HIST_LEN; i++)
            begin
                s = slot_of(a, side_path[side][i % 32], i);
                if (side_hist[side][i])
                    sum += weight_tbl[s];
                else
                    sum -= weight_tbl[s];
            end
            pred = (sum >= 0);
            mag = (sum < 0) ? -sum : sum;
            if (kind == OP_RETIRE && (mag < threshold || pred != t))
            begin
                train_now = 1'b1;
                bias_tbl[a[hpp_pkg::BIDX_BITS-1:0]] =
                    step_weight(bias_tbl[a[hpp_pkg::BIDX_BITS-1:0]], t);
                // Colliding positions accumulate since the loop runs in order.
                for (int i = 0; i < hpp_pkg::HIST_LEN; i++)
                begin
                    s = slot_of(a, side_path[side][i % 32], i);
                    weight_tbl[s] = step_weight(weight_tbl[s], side_hist[side][i] == t);
                end
            end
        end
        if (b || c)
        begin
            side_hist[side] = {side_hist[side][30:0], c ? t : 1'b1};
            for (int i = 31; i > 0; i--)
                side_path[side][i] = side_path[side][i-1];
            side_path[side][0] = a;
        end
        v.valid = c;
        v.taken = pred;
        v.sum = sum[hpp_pkg::SUM_BITS-1:0];
        v.trained = train_now;
        return v;
    endfunction

    task automatic send_uop(uop_kind_t kind, logic [31:0] a, bit c, bit b, bit t);
        int gap;
        s_tdata  <= {5'b0, t, b, c, a};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_verdicts.push_back(predict_uop(kind, a, c, b, t));
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(6, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops the sender and lets the block go fully idle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [hpp_pkg::THR_BITS-1:0] value);
        drain_block();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        threshold = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_uop();
        logic [31:0] a;
        bit c;
        a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(15)] : $urandom;
        c = ($urandom_range(99) < 70);
        // Per-address bias makes the outcomes learnable.
        send_uop(uop_kind_t'($urandom_range(1)), a, c, $urandom_range(1),
                 ($urandom_range(99) < 80) ^ a[3]);
    endtask

    task automatic test_directed();
        send_uop(OP_FETCH,  32'h0000_0000, 1, 1, 1);
        send_uop(OP_RETIRE, 32'h0000_0000, 1, 1, 1);
        send_uop(OP_RETIRE, 32'hFFFF_FFFF, 1, 1, 0);
        send_uop(OP_FETCH,  32'hFFFF_FFFF, 1, 1, 0);
        send_uop(OP_RETIRE, 32'h0040_1000, 0, 0, 1);
        send_uop(OP_FETCH,  32'h0040_1004, 0, 0, 0);
        send_uop(OP_RETIRE, 32'h0040_1008, 0, 1, 0);
        send_uop(OP_FETCH,  32'h0040_100C, 0, 1, 1);
        // Conditional flag alone still counts as a branch.
        send_uop(OP_RETIRE, 32'h0040_1010, 1, 0, 1);
        send_uop(OP_FETCH,  32'h0040_1010, 1, 0, 0);
        send_uop(OP_RETIRE, 32'hAAAA_5555, 1, 1, 0);
        send_uop(OP_RETIRE, 32'h5555_AAAA, 1, 1, 1);
        send_uop(OP_RETIRE, 32'h0040_1010, 1, 1, 1);
        send_uop(OP_FETCH,  32'h0040_1010, 1, 1, 1);
        send_uop(OP_RETIRE, 32'h8000_0001, 1, 1, 0);
        send_uop(OP_FETCH,  32'h7FFF_FFFE, 0, 1, 0);
    endtask

    task automatic test_thresholds();
        write_threshold(13'd0);
        repeat (12) send_random_uop();
        write_threshold(13'd4224);
        repeat (12) send_random_uop();
        write_threshold(13'($urandom_range(4224, 1)));
        repeat (12) send_random_uop();
    endtask

    // One address taken again and again fills history and path with the same
    // values; its slots and bias climb to +127, then the bias falls to -128.
    task automatic test_saturation();
        write_threshold(13'd4224);
        repeat (180) send_uop(OP_RETIRE, 32'h1234_5678, 1, 1, 1);
        repeat (300) send_uop(OP_RETIRE, 32'h1234_5678, 1, 1, 0);
        repeat (20) send_uop(OP_FETCH, 32'h1234_5678, 1, 1, 1);
    endtask

    task automatic test_random(int count);
        write_threshold(hpp_pkg::THR_RESET);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 58) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 58) : 0;
            for (int k = 0; k < count / 4; k++)
            begin
                send_random_uop();
                if (k == count / 8)
                    drain_block();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver side: random stalls and the result check.
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[16:0];
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected valid=%b taken=%b sum=%0d ",
                                      "trained=%b, got valid=%b taken=%b sum=%0d trained=%b"},
                                     want.valid, want.taken, $signed(want.sum), want.trained,
                                     got.valid, got.taken, $signed(got.sum), got.trained);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[hashed_path_perceptron_predictor] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        threshold = hpp_pkg::THR_RESET;
        side_hist[0] = '0;
        side_hist[1] = '0;
        foreach (weight_tbl[i]) weight_tbl[i] = 0;
        foreach (bias_tbl[i]) bias_tbl[i] = 0;
        foreach (side_path[s, i]) side_path[s][i] = '0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_thresholds();
        test_saturation();
        test_random(448);
        drain_block();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("[hashed_path_perceptron_predictor] OK");
        else
            $display("[hashed_path_perceptron_predictor] ERROR");
        $finish;
    end
endmodule

>>> sim.f
hdl/hpp_pkg.sv
hdl/hpp_datapath.sv
hdl/hpp_ctrl.sv
hdl/hashed_path_perceptron_predictor.sv
sim/hashed_path_perceptron_predictor_tb.sv
